>>> hdl/scp_pkg.sv
// scp_pkg: types, widths and latencies shared by the segment closest-points block.
// No dependencies; every hdl/ module imports it.
package scp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int DIFF_W = COORD_WIDTH + 1;          // end - start
  localparam int PROD_W = 2 * DIFF_W;               // product of two diffs
  localparam int DOT_W  = PROD_W + 2;               // sum of three products, signed
  localparam int HALF_W = DOT_W / 2;                // multiplier split point
  localparam int WIDE_W = 2 * DOT_W;                // product of two dots
  localparam int Q_W    = FRAC_BITS + 1;            // s, t in Q0.16 incl. 1.0
  localparam int PT_W   = DIFF_W + Q_W + 1;         // diff * s
  localparam int SQ_W   = 2 * COORD_WIDTH;          // squared distance below saturation

  localparam int MUL_LAT   = 2;
  localparam int RATIO_LAT = FRAC_BITS + 1;
  localparam int SQRT_LAT  = COORD_WIDTH;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [DOT_W-1:0]       dot_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;
  typedef logic        [Q_W-1:0]         frac_t;

  localparam frac_t FRAC_ONE = frac_t'(1) << FRAC_BITS;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_start_z;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t a_end_z;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_start_z;
    coord_t b_end_x;
    coord_t b_end_y;
    coord_t b_end_z;
  } seg_in_t;

  typedef struct packed {
    coord_t                 near_a_x;
    coord_t                 near_a_y;
    coord_t                 near_a_z;
    coord_t                 near_b_x;
    coord_t                 near_b_y;
    coord_t                 near_b_z;
    logic [COORD_WIDTH-1:0] gap;
  } seg_out_t;

  typedef struct packed {
    coord_t [2:0] pa;
    coord_t [2:0] pb;
    diff_t  [2:0] da;
    diff_t  [2:0] db;
  } geo_t;

  typedef struct packed {
    dot_t a;
    dot_t b;
    dot_t c;
    dot_t e;
    dot_t f;
  } dots_t;

  typedef struct packed {
    geo_t  geo;
    dots_t dots;
  } qent_t;

  // how t is settled after the first pass
  typedef enum logic [1:0] {
    MODE_T_LOW,
    MODE_T_HIGH,
    MODE_T_FREE
  } tmode_t;

endpackage

>>> hdl/scp_mul.sv
// scp_mul: two-stage signed multiplier for dot-product-wide operands,
// built from four half-width partial products. Depends on scp_pkg.
module scp_mul import scp_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  dot_t  x_i,
  input  dot_t  y_i,
  output wide_t p_o
);

  logic        [HALF_W-1:0]   xl, yl;
  logic signed [HALF_W-1:0]   xh, yh;
  logic        [2*HALF_W-1:0] pll_r;
  logic signed [2*HALF_W:0]   plh_r, phl_r;
  logic signed [2*HALF_W-1:0] phh_r;
  wide_t                      p_r;

  assign xl = x_i[HALF_W-1:0];
  assign yl = y_i[HALF_W-1:0];
  assign xh = x_i[DOT_W-1:HALF_W];
  assign yh = y_i[DOT_W-1:HALF_W];

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r <= xl * yl;
      plh_r <= $signed({1'b0, xl}) * yh;
      phl_r <= xh * $signed({1'b0, yl});
      phh_r <= xh * yh;
      p_r   <= (WIDE_W'(phh_r) <<< (2 * HALF_W))
             + (WIDE_W'(plh_r) <<< HALF_W)
             + (WIDE_W'(phl_r) <<< HALF_W)
             + $signed(WIDE_W'(pll_r));
    end
  end

  assign p_o = p_r;

endmodule

>>> hdl/scp_ratio.sv
// scp_ratio: pipelined clamped ratio n/d in Q0.16, one quotient bit per stage.
// Depends on scp_pkg. All stages advance only while en is high.
module scp_ratio import scp_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  wide_t num_i,
  input  wide_t den_i,
  output frac_t q_o
);

  logic [WIDE_W-1:0]    n_r    [FRAC_BITS+1];
  logic [WIDE_W-1:0]    d_r    [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] q_r    [FRAC_BITS+1];
  logic                 zero_r [FRAC_BITS+1];
  logic                 full_r [FRAC_BITS+1];
  logic                 zero_c, full_c;

  assign zero_c = num_i[WIDE_W-1] || (num_i == '0);
  assign full_c = !zero_c && (num_i >= den_i);

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]    <= num_i;
      d_r[0]    <= den_i;
      q_r[0]    <= '0;
      zero_r[0] <= zero_c;
      full_r[0] <= full_c;
    end
  end

  // restoring step; inside the live range 0 < n < d holds
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    logic [WIDE_W:0] n2, n_nxt;
    logic            take;

    always_comb begin
      n2    = {n_r[k-1], 1'b0};
      take  = n2 >= {1'b0, d_r[k-1]};
      n_nxt = take ? n2 - {1'b0, d_r[k-1]} : n2;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= n_nxt[WIDE_W-1:0];
        d_r[k]    <= d_r[k-1];
        q_r[k]    <= {q_r[k-1][FRAC_BITS-2:0], take};
        zero_r[k] <= zero_r[k-1];
        full_r[k] <= full_r[k-1];
      end
    end
  end

  assign q_o = zero_r[FRAC_BITS] ? '0 :
               full_r[FRAC_BITS] ? FRAC_ONE : {1'b0, q_r[FRAC_BITS]};

endmodule

>>> hdl/scp_sqrt.sv
// scp_sqrt: pipelined integer square root, one root bit per stage.
// Depends on scp_pkg. All stages advance only while en is high.
module scp_sqrt import scp_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [SQ_W-1:0]        sq_i,
  output logic [COORD_WIDTH-1:0] root_o
);

  logic [SQ_W-1:0] op_r  [SQRT_LAT];
  logic [SQ_W-1:0] res_r [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
    localparam logic [SQ_W-1:0] BITV = {{(SQ_W-1){1'b0}}, 1'b1} << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] op_in, res_in, trial, op_nxt, res_nxt;
    logic            take;

    if (k == 0) begin : g_first
      assign op_in  = sq_i;
      assign res_in = '0;
    end else begin : g_next
      assign op_in  = op_r[k-1];
      assign res_in = res_r[k-1];
    end

    always_comb begin
      trial   = res_in + BITV;
      take    = op_in >= trial;
      op_nxt  = take ? op_in - trial : op_in;
      res_nxt = take ? (res_in >> 1) + BITV : (res_in >> 1);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        op_r[k]  <= op_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root_o = res_r[SQRT_LAT-1][COORD_WIDTH-1:0];

endmodule

>>> hdl/scp_front.sv
// scp_front: accepts segment pairs, forms direction vectors and the five dot
// products, and pushes them into the queue. Depends on scp_pkg.
module scp_front import scp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  seg_in_t in_data,
  output logic    push,
  output qent_t   push_data,
  input  logic    q_full
);

  logic        adv;
  logic        f0_vld_r, f1_vld_r;
  geo_t        geo_c, f0_geo_r, f1_geo_r;
  diff_t [2:0] rv_c, f0_rv_r;
  logic signed [PROD_W-1:0] aa_r [3], bb_r [3], cc_r [3], ee_r [3], ff_r [3];

  // whole front holds while its last item cannot enter the queue
  assign adv      = !f1_vld_r || !q_full;
  assign in_ready = adv;
  assign push     = f1_vld_r && !q_full;

  always_comb begin
    geo_c.pa[0] = in_data.a_start_x;
    geo_c.pa[1] = in_data.a_start_y;
    geo_c.pa[2] = in_data.a_start_z;
    geo_c.pb[0] = in_data.b_start_x;
    geo_c.pb[1] = in_data.b_start_y;
    geo_c.pb[2] = in_data.b_start_z;
    geo_c.da[0] = DIFF_W'(in_data.a_end_x) - DIFF_W'(in_data.a_start_x);
    geo_c.da[1] = DIFF_W'(in_data.a_end_y) - DIFF_W'(in_data.a_start_y);
    geo_c.da[2] = DIFF_W'(in_data.a_end_z) - DIFF_W'(in_data.a_start_z);
    geo_c.db[0] = DIFF_W'(in_data.b_end_x) - DIFF_W'(in_data.b_start_x);
    geo_c.db[1] = DIFF_W'(in_data.b_end_y) - DIFF_W'(in_data.b_start_y);
    geo_c.db[2] = DIFF_W'(in_data.b_end_z) - DIFF_W'(in_data.b_start_z);
    rv_c[0]     = DIFF_W'(in_data.a_start_x) - DIFF_W'(in_data.b_start_x);
    rv_c[1]     = DIFF_W'(in_data.a_start_y) - DIFF_W'(in_data.b_start_y);
    rv_c[2]     = DIFF_W'(in_data.a_start_z) - DIFF_W'(in_data.b_start_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r <= 1'b0;
      f1_vld_r <= 1'b0;
    end else if (adv) begin
      f0_vld_r <= in_valid;
      f1_vld_r <= f0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_geo_r <= geo_c;
      f0_rv_r  <= rv_c;
      f1_geo_r <= f0_geo_r;
      for (int i = 0; i < 3; i++) begin
        aa_r[i] <= $signed(f0_geo_r.da[i]) * $signed(f0_geo_r.da[i]);
        ee_r[i] <= $signed(f0_geo_r.db[i]) * $signed(f0_geo_r.db[i]);
        bb_r[i] <= $signed(f0_geo_r.da[i]) * $signed(f0_geo_r.db[i]);
        cc_r[i] <= $signed(f0_geo_r.da[i]) * $signed(f0_rv_r[i]);
        ff_r[i] <= $signed(f0_geo_r.db[i]) * $signed(f0_rv_r[i]);
      end
    end
  end

  always_comb begin
    push_data.geo    = f1_geo_r;
    push_data.dots.a = DOT_W'(aa_r[0]) + DOT_W'(aa_r[1]) + DOT_W'(aa_r[2]);
    push_data.dots.b = DOT_W'(bb_r[0]) + DOT_W'(bb_r[1]) + DOT_W'(bb_r[2]);
    push_data.dots.c = DOT_W'(cc_r[0]) + DOT_W'(cc_r[1]) + DOT_W'(cc_r[2]);
    push_data.dots.e = DOT_W'(ee_r[0]) + DOT_W'(ee_r[1]) + DOT_W'(ee_r[2]);
    push_data.dots.f = DOT_W'(ff_r[0]) + DOT_W'(ff_r[1]) + DOT_W'(ff_r[2]);
  end

endmodule

>>> hdl/scp_queue.sv
// scp_queue: short FIFO of geometry and dot-product items between front and back.
// Depends on scp_pkg.
module scp_queue import scp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output qent_t pop_data,
  output logic  empty
);

  qent_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r;

  assign full     = cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> !empty)
    else $error("queue lost a pushed item");

endmodule

>>> hdl/scp_back.sv
// scp_back: clamped-parameter solve, closest points and distance, as one
// stall-together pipeline ending in the output register.
// Depends on scp_pkg, scp_mul, scp_ratio, scp_sqrt.
module scp_back import scp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  qent_t    q_data,
  input  logic     q_empty,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output seg_out_t out_data
);

  localparam int LAT = MUL_LAT + 1 + RATIO_LAT + MUL_LAT + 2 + RATIO_LAT + 4 + SQRT_LAT + 1;

  logic           adv;
  logic [LAT-1:0] vld_r;

  // first products
  wide_t p_ae, p_bb, p_bf, p_ce;
  qent_t ma_ctx_r [MUL_LAT];
  // den / s numerator
  qent_t d0_ctx_r;
  wide_t d0_den_r, d0_sn_r, div1_num;
  // first ratio
  frac_t s1;
  qent_t v1_ctx_r [RATIO_LAT];
  // b * s1
  wide_t p_bs;
  qent_t m2_ctx_r [MUL_LAT];
  frac_t m2_s1_r  [MUL_LAT];
  // t numerator, decision
  qent_t  t0_ctx_r;
  frac_t  t0_s1_r;
  wide_t  t0_tn_r, t0_td_r;
  tmode_t mode_c, t1_mode_r;
  wide_t  ns_c, t1_ns_r, t1_tn_r, t1_td_r;
  dot_t   t1_a_r;
  geo_t   t1_geo_r;
  frac_t  t1_s1_r;
  // second ratios
  frac_t  s2, t2;
  geo_t   v2_geo_r  [RATIO_LAT];
  frac_t  v2_s1_r   [RATIO_LAT];
  tmode_t v2_mode_r [RATIO_LAT];
  // points
  frac_t  sel_s, sel_t;
  geo_t   p0_geo_r;
  logic signed [PT_W-1:0] p0_ma_r [3], p0_mb_r [3], p1_sa [3], p1_sb [3];
  coord_t p1_ca_r [3], p1_cb_r [3];
  // distance
  diff_t  q0_dd [3];
  logic signed [PROD_W-1:0] q0_sq_r [3];
  coord_t q0_ca_r [3], q0_cb_r [3];
  logic [DOT_W-1:0] q1_sum;
  logic [SQ_W-1:0]  q1_sq_r;
  logic             q1_sat_r;
  coord_t           q1_ca_r [3], q1_cb_r [3];
  logic [COORD_WIDTH-1:0] root;
  coord_t sr_ca_r [SQRT_LAT][3];
  coord_t sr_cb_r [SQRT_LAT][3];
  logic   sr_sat_r [SQRT_LAT];
  seg_out_t out_data_r;

  assign adv       = !vld_r[LAT-1] || out_ready;
  assign q_pop     = adv && !q_empty;
  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], !q_empty};
    end
  end

  scp_mul u_mul_ae (.clk(clk), .en(adv), .x_i(q_data.dots.a), .y_i(q_data.dots.e), .p_o(p_ae));
  scp_mul u_mul_bb (.clk(clk), .en(adv), .x_i(q_data.dots.b), .y_i(q_data.dots.b), .p_o(p_bb));
  scp_mul u_mul_bf (.clk(clk), .en(adv), .x_i(q_data.dots.b), .y_i(q_data.dots.f), .p_o(p_bf));
  scp_mul u_mul_ce (.clk(clk), .en(adv), .x_i(q_data.dots.c), .y_i(q_data.dots.e), .p_o(p_ce));

  // a zero-length segment makes den zero, so s1 falls to zero there too
  assign div1_num = (d0_den_r == '0) ? '0 : d0_sn_r;

  scp_ratio u_div_s1 (.clk(clk), .en(adv), .num_i(div1_num), .den_i(d0_den_r), .q_o(s1));

  scp_mul u_mul_bs (
    .clk(clk), .en(adv),
    .x_i(v1_ctx_r[RATIO_LAT-1].dots.b), .y_i(DOT_W'(s1)), .p_o(p_bs)
  );

  always_comb begin
    if (t0_ctx_r.dots.e == '0 || t0_tn_r < 0) begin
      mode_c = MODE_T_LOW;
    end else if (t0_tn_r > t0_td_r) begin
      mode_c = MODE_T_HIGH;
    end else begin
      mode_c = MODE_T_FREE;
    end
    if (mode_c == MODE_T_HIGH) begin
      ns_c = WIDE_W'(t0_ctx_r.dots.b) - WIDE_W'(t0_ctx_r.dots.c);
    end else begin
      ns_c = -WIDE_W'(t0_ctx_r.dots.c);
    end
  end

  scp_ratio u_div_s2 (.clk(clk), .en(adv), .num_i(t1_ns_r), .den_i(WIDE_W'(t1_a_r)), .q_o(s2));
  scp_ratio u_div_t  (.clk(clk), .en(adv), .num_i(t1_tn_r), .den_i(t1_td_r), .q_o(t2));

  always_comb begin
    case (v2_mode_r[RATIO_LAT-1])
      MODE_T_LOW: begin
        sel_s = s2;
        sel_t = '0;
      end
      MODE_T_HIGH: begin
        sel_s = s2;
        sel_t = FRAC_ONE;
      end
      MODE_T_FREE: begin
        sel_s = v2_s1_r[RATIO_LAT-1];
        sel_t = t2;
      end
      default: begin
        sel_s = '0;
        sel_t = '0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1_sa[i] = PT_W'($signed(p0_geo_r.pa[i])) + (p0_ma_r[i] >>> FRAC_BITS);
      p1_sb[i] = PT_W'($signed(p0_geo_r.pb[i])) + (p0_mb_r[i] >>> FRAC_BITS);
      q0_dd[i] = DIFF_W'(p1_cb_r[i]) - DIFF_W'(p1_ca_r[i]);
    end
    q1_sum = DOT_W'(q0_sq_r[0]) + DOT_W'(q0_sq_r[1]) + DOT_W'(q0_sq_r[2]);
  end

  scp_sqrt u_sqrt (.clk(clk), .en(adv), .sq_i(q1_sat_r ? '0 : q1_sq_r), .root_o(root));

  always_ff @(posedge clk) begin
    if (adv) begin
      ma_ctx_r[0] <= q_data;
      for (int k = 1; k < MUL_LAT; k++) ma_ctx_r[k] <= ma_ctx_r[k-1];

      d0_ctx_r <= ma_ctx_r[MUL_LAT-1];
      d0_den_r <= p_ae - p_bb;
      d0_sn_r  <= p_bf - p_ce;

      v1_ctx_r[0] <= d0_ctx_r;
      for (int k = 1; k < RATIO_LAT; k++) v1_ctx_r[k] <= v1_ctx_r[k-1];

      m2_ctx_r[0] <= v1_ctx_r[RATIO_LAT-1];
      m2_s1_r[0]  <= s1;
      for (int k = 1; k < MUL_LAT; k++) begin
        m2_ctx_r[k] <= m2_ctx_r[k-1];
        m2_s1_r[k]  <= m2_s1_r[k-1];
      end

      t0_ctx_r <= m2_ctx_r[MUL_LAT-1];
      t0_s1_r  <= m2_s1_r[MUL_LAT-1];
      t0_tn_r  <= p_bs + (WIDE_W'(m2_ctx_r[MUL_LAT-1].dots.f) <<< FRAC_BITS);
      t0_td_r  <= WIDE_W'(m2_ctx_r[MUL_LAT-1].dots.e) <<< FRAC_BITS;

      t1_mode_r <= mode_c;
      t1_ns_r   <= ns_c;
      t1_tn_r   <= t0_tn_r;
      t1_td_r   <= t0_td_r;
      t1_a_r    <= t0_ctx_r.dots.a;
      t1_geo_r  <= t0_ctx_r.geo;
      t1_s1_r   <= t0_s1_r;

      v2_geo_r[0]  <= t1_geo_r;
      v2_s1_r[0]   <= t1_s1_r;
      v2_mode_r[0] <= t1_mode_r;
      for (int k = 1; k < RATIO_LAT; k++) begin
        v2_geo_r[k]  <= v2_geo_r[k-1];
        v2_s1_r[k]   <= v2_s1_r[k-1];
        v2_mode_r[k] <= v2_mode_r[k-1];
      end

      p0_geo_r <= v2_geo_r[RATIO_LAT-1];
      for (int i = 0; i < 3; i++) begin
        p0_ma_r[i] <= $signed(v2_geo_r[RATIO_LAT-1].da[i]) * $signed({1'b0, sel_s});
        p0_mb_r[i] <= $signed(v2_geo_r[RATIO_LAT-1].db[i]) * $signed({1'b0, sel_t});
        p1_ca_r[i] <= p1_sa[i][COORD_WIDTH-1:0];
        p1_cb_r[i] <= p1_sb[i][COORD_WIDTH-1:0];
        q0_sq_r[i] <= q0_dd[i] * q0_dd[i];
        q0_ca_r[i] <= p1_ca_r[i];
        q0_cb_r[i] <= p1_cb_r[i];
        q1_ca_r[i] <= q0_ca_r[i];
        q1_cb_r[i] <= q0_cb_r[i];
      end

      q1_sq_r  <= q1_sum[SQ_W-1:0];
      q1_sat_r <= |q1_sum[DOT_W-1:SQ_W];

      sr_ca_r[0]  <= q1_ca_r;
      sr_cb_r[0]  <= q1_cb_r;
      sr_sat_r[0] <= q1_sat_r;
      for (int k = 1; k < SQRT_LAT; k++) begin
        sr_ca_r[k]  <= sr_ca_r[k-1];
        sr_cb_r[k]  <= sr_cb_r[k-1];
        sr_sat_r[k] <= sr_sat_r[k-1];
      end

      out_data_r.near_a_x <= sr_ca_r[SQRT_LAT-1][0];
      out_data_r.near_a_y <= sr_ca_r[SQRT_LAT-1][1];
      out_data_r.near_a_z <= sr_ca_r[SQRT_LAT-1][2];
      out_data_r.near_b_x <= sr_cb_r[SQRT_LAT-1][0];
      out_data_r.near_b_y <= sr_cb_r[SQRT_LAT-1][1];
      out_data_r.near_b_z <= sr_cb_r[SQRT_LAT-1][2];
      out_data_r.gap      <= sr_sat_r[SQRT_LAT-1] ? '1 : root;
    end
  end

endmodule

>>> hdl/segment_closest_points.sv
// segment_closest_points: top level; front, queue and back wired together.
// Depends on scp_pkg, scp_front, scp_queue, scp_back.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------
//   in_      | in  | in_valid / in_ready  | seg_in_t, two segments
//   out_     | out | out_valid/out_ready  | seg_out_t, two points and gap
//
// One item per cycle sustained while out_ready holds. Items pass the
// front, the queue and the back; the back's depth is set by two 17-stage
// ratio dividers in series and the 32-stage square root.
// Reset is synchronous, active low, and clears only valid and queue state.
// A stalled output holds the whole back; the 4-entry queue lets the front
// keep taking items until it fills.
module segment_closest_points import scp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  seg_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output seg_out_t out_data
);

  logic  push, pop, q_full, q_empty;
  qent_t push_data, pop_data;

  scp_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .push(push), .push_data(push_data), .q_full(q_full)
  );

  scp_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .pop_data(pop_data), .empty(q_empty)
  );

  scp_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_data(pop_data), .q_empty(q_empty), .q_pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
